### hdl/watchdog_timer_with_key_lock_top_defines.svh
// Assertion macros shared by the watchdog RTL.
// Build with NO_ASSERTIONS defined to leave them out.
`ifndef WATCHDOG_TIMER_WITH_KEY_LOCK_TOP_DEFINES_SVH
`define WATCHDOG_TIMER_WITH_KEY_LOCK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset
`define WDTK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define WDTK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WDTK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define WDTK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/wdtk_pkg.sv
package wdtk_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [ADDR_W-1:0] OFF_CTRL   = 12'h000;
  localparam logic [ADDR_W-1:0] OFF_LOAD   = 12'h004;
  localparam logic [ADDR_W-1:0] OFF_COUNT  = 12'h008;
  localparam logic [ADDR_W-1:0] OFF_KEY    = 12'h00C;
  localparam logic [ADDR_W-1:0] OFF_STATUS = 12'h010;

  localparam logic [DATA_W-1:0] KEY_FEED     = 32'h5A5A_5A5A;
  localparam logic [DATA_W-1:0] KEY_LOCK     = 32'h1ACC_E551;
  localparam logic [DATA_W-1:0] RELOAD_RESET = 32'h0000_FFFF;

  localparam int unsigned CTRL_ENABLE_BIT = 0;
  localparam int unsigned CTRL_INTEN_BIT  = 1;
  localparam int unsigned STATUS_TO_BIT   = 0;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq;
  } result_t;

endpackage

### hdl/wdtk_in_reg.sv
module wdtk_in_reg
  import wdtk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  // Hold the registered transaction while the result side cannot take it
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item <= in_item;
    end
  end

endmodule

### hdl/wdtk_core.sv
`include "watchdog_timer_with_key_lock_top_defines.svh"

module wdtk_core
  import wdtk_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result_next
);

  logic [DATA_W-1:0] control;
  logic [DATA_W-1:0] reload_value;
  logic [DATA_W-1:0] count;
  logic [DATA_W-1:0] key_value;
  logic              timeout_flag;
  logic              armed;
  logic              irq_level;

  logic [DATA_W-1:0] control_next;
  logic [DATA_W-1:0] reload_value_next;
  logic [DATA_W-1:0] count_next;
  logic [DATA_W-1:0] key_value_next;
  logic              timeout_flag_next;
  logic              armed_next;
  logic              irq_level_next;
  logic [DATA_W-1:0] count_dec;
  logic [DATA_W-1:0] rdata_next;

  // Count saturates at zero
  assign count_dec = (count != '0) ? count - DATA_W'(1) : '0;

  always_comb begin
    control_next      = control;
    reload_value_next = reload_value;
    count_next        = count;
    key_value_next    = key_value;
    timeout_flag_next = timeout_flag;
    armed_next        = armed;
    irq_level_next    = irq_level;
    rdata_next        = '0;
    if (fire) begin
      case (item.op)
        OP_READ: begin
          case (item.addr)
            OFF_CTRL:   rdata_next = control;
            OFF_LOAD:   rdata_next = reload_value;
            OFF_COUNT:  rdata_next = count;
            OFF_KEY:    rdata_next = key_value;
            OFF_STATUS: rdata_next = {{(DATA_W-1){1'b0}}, timeout_flag};
            default:    rdata_next = '0;
          endcase
        end
        OP_WRITE: begin
          case (item.addr)
            OFF_CTRL: begin
              // Drop control writes while locked
              if (key_value != KEY_LOCK) begin
                control_next = item.wdata;
                if (item.wdata[CTRL_ENABLE_BIT]) begin
                  armed_next = 1'b1;
                end
              end
            end
            OFF_LOAD: begin
              reload_value_next = item.wdata;
              count_next        = item.wdata;
            end
            OFF_KEY: begin
              key_value_next = item.wdata;
              if (item.wdata == KEY_FEED) begin
                count_next = reload_value;
              end
            end
            OFF_STATUS: begin
              if (item.wdata[STATUS_TO_BIT]) begin
                timeout_flag_next = 1'b0;
                irq_level_next    = 1'b0;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (armed) begin
            if (!control[CTRL_ENABLE_BIT]) begin
              armed_next = 1'b0;
            end else begin
              count_next = count_dec;
              if (count_dec == '0) begin
                timeout_flag_next = 1'b1;
                armed_next        = 1'b0;
                if (control[CTRL_INTEN_BIT]) begin
                  irq_level_next = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result_next.rdata = rdata_next;
  assign result_next.irq   = irq_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      control      <= '0;
      reload_value <= RELOAD_RESET;
      count        <= RELOAD_RESET;
      key_value    <= '0;
      timeout_flag <= 1'b0;
      armed        <= 1'b0;
      irq_level    <= 1'b0;
    end else begin
      control      <= control_next;
      reload_value <= reload_value_next;
      count        <= count_next;
      key_value    <= key_value_next;
      timeout_flag <= timeout_flag_next;
      armed        <= armed_next;
      irq_level    <= irq_level_next;
    end
  end

  `WDTK_ASSERT_IMP(a_irq_needs_status, clk, rst, irq_level, timeout_flag, "irq without status")
  `WDTK_ASSERT_NXT(a_expiry_disarms, clk, rst, fire && item.op == OP_TICK && armed && control[CTRL_ENABLE_BIT] && count <= DATA_W'(1), !armed && timeout_flag && count == '0, "expiry did not disarm")
  `WDTK_ASSERT_NXT(a_lock_holds_ctrl, clk, rst, fire && item.op == OP_WRITE && item.addr == OFF_CTRL && key_value == KEY_LOCK, $stable(control) && armed == $past(armed), "locked control changed")
  `WDTK_ASSERT_NXT(a_count_no_rise, clk, rst, !(fire && item.op == OP_WRITE && (item.addr == OFF_LOAD || item.addr == OFF_KEY)), count <= $past(count), "count rose without reload")

endmodule

### hdl/wdtk_out_reg.sv
module wdtk_out_reg
  import wdtk_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  input  result_t result_next,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result
);

  // Move on whenever the result register is empty or being drained
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

### hdl/watchdog_timer_with_key_lock_top.sv
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------
// input   | in_valid / in_stall  | op[1:0] addr[11:0] wdata[31:0]
// output  | out_valid / out_stall| rdata[31:0] irq
//
// One transaction per cycle sustained while out_stall is low. A transaction
// taken into the input register passes through the register logic into the
// result register as it advances; out_valid then rises. Reset (rst,
// synchronous) empties both registers and sets the watchdog registers to their
// reset values. A stall on the output holds the result register and, once the
// input register is also full, raises in_stall in the same cycle.
module watchdog_timer_with_key_lock_top
  import wdtk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   op,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] rdata,
  output logic              irq
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  result_t result_next;
  result_t result;

  assign in_item.op    = op;
  assign in_item.addr  = addr;
  assign in_item.wdata = wdata;

  wdtk_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  assign fire = item_valid && advance;

  wdtk_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .result_next (result_next)
  );

  wdtk_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (item_valid),
    .result_next (result_next),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign rdata = result.rdata;
  assign irq   = result.irq;

endmodule
